FILE: rtl/core/cbss_pkg.sv
// Shared types, codes and the helper function of the chunked bitmap set seek block.
package cbss_pkg;

    localparam int WORD_W  = 64;
    localparam int KIND_W  = 3;
    localparam int FIELD_W = 16;
    localparam int COUNT_W = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SEEK   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NEXT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REWIND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HI = 2'd1;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_DISPATCH,
        CMD_CLR,
        CMD_ADD_WR,
        CMD_CH_RD,
        CMD_CH_EVAL,
        CMD_W_EVAL,
        CMD_EMIT
    } t_cmd;

    typedef struct packed {
        logic need_add;
        logic need_search;
        logic is_clear;
        logic clr_last;
        logic ch_hit;
        logic ch_skip;
        logic ch_last;
        logic w_hit;
        logic w_last;
        logic out_free;
    } t_stat;

    // Index of the lowest set bit, found by halving the word six times.
    function automatic logic [5:0] lowest_set(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] v;
        logic [5:0]        n;
        v = w;
        n = '0;
        for (int k = 5; k >= 0; k--) begin
            if ((v & ((64'd1 << (1 << k)) - 64'd1)) == '0) begin
                n[k] = 1'b1;
                v    = v >> (1 << k);
            end
        end
        return n;
    endfunction

endpackage

FILE: rtl/core/cbss_ctrl.sv
// Controller state machine that sequences add, seek, clear and result hand-off.
module cbss_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  cbss_pkg::t_stat i_st,
    output cbss_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_CLEAR,
        S_ADD_WR,
        S_CH_RD,
        S_CH_EVAL,
        S_W_EVAL,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_pend;
    logic   n_pend;

    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        o_cmd   = cbss_pkg::CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd   = cbss_pkg::CMD_ACCEPT;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd = cbss_pkg::CMD_DISPATCH;
                if (i_st.is_clear) begin
                    n_state = S_CLEAR;
                    n_pend  = 1'b1;
                end else if (i_st.need_add) begin
                    n_state = S_ADD_WR;
                end else if (i_st.need_search) begin
                    n_state = S_CH_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CLEAR: begin
                o_cmd = cbss_pkg::CMD_CLR;
                if (i_st.clr_last) begin
                    n_state = r_pend ? S_DONE : S_IDLE;
                    n_pend  = 1'b0;
                end
            end
            S_ADD_WR: begin
                o_cmd   = cbss_pkg::CMD_ADD_WR;
                n_state = S_DONE;
            end
            S_CH_RD: begin
                o_cmd   = cbss_pkg::CMD_CH_RD;
                n_state = S_CH_EVAL;
            end
            S_CH_EVAL: begin
                o_cmd = cbss_pkg::CMD_CH_EVAL;
                if (i_st.ch_hit) begin
                    n_state = S_DONE;
                end else if (i_st.ch_skip) begin
                    n_state = i_st.ch_last ? S_DONE : S_CH_RD;
                end else begin
                    n_state = S_W_EVAL;
                end
            end
            S_W_EVAL: begin
                o_cmd = cbss_pkg::CMD_W_EVAL;
                if (i_st.w_hit) begin
                    n_state = S_DONE;
                end else if (!i_st.w_last) begin
                    n_state = S_W_EVAL;
                end else begin
                    n_state = i_st.ch_last ? S_DONE : S_CH_RD;
                end
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    o_cmd   = cbss_pkg::CMD_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

endmodule

FILE: rtl/core/cbss_dp.sv
// Datapath: bitmap word memory, chunk summary memory, cursor, count and result register.
module cbss_dp #(
    parameter int ID_BITS    = 16,
    parameter int CHUNK_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cbss_pkg::t_cmd                    i_cmd,
    input  logic                              i_cfg_we,
    input  logic [cbss_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cbss_pkg::FIELD_W-1:0]      i_cfg_data,
    input  logic [cbss_pkg::KIND_W-1:0]       i_kind,
    input  logic [cbss_pkg::FIELD_W-1:0]      i_id,
    input  logic [cbss_pkg::FIELD_W-1:0]      i_tgt,
    output cbss_pkg::t_stat                   o_st,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [39:0]                       o_m_tdata
);

    localparam int EFF   = (CHUNK_BITS < ID_BITS) ? CHUNK_BITS : ID_BITS;
    localparam int CIB   = ID_BITS - EFF;
    localparam int NCH   = 1 << CIB;
    localparam int CAW   = (CIB > 0) ? CIB : 1;
    localparam int CCW   = CIB + 1;
    localparam int WOB   = EFF - 6;
    localparam int WPC   = 1 << WOB;
    localparam int WCW   = WOB + 1;
    localparam int WAW   = ID_BITS - 6;
    localparam int NWORD = 1 << WAW;
    localparam int TW    = ((ID_BITS > cbss_pkg::FIELD_W) ? ID_BITS : cbss_pkg::FIELD_W) + 1;
    localparam int MW    = 1 + 2 * EFF;
    localparam int W     = cbss_pkg::WORD_W;

    logic [W-1:0]   mem_word [NWORD];
    logic [MW-1:0]  mem_meta [NCH];
    logic [W-1:0]   r_word_q;
    logic [MW-1:0]  r_meta_q;

    logic [cbss_pkg::KIND_W-1:0]  r_kind;
    logic [cbss_pkg::FIELD_W-1:0] r_id;
    logic [cbss_pkg::FIELD_W-1:0] r_tgt;
    logic [cbss_pkg::FIELD_W-1:0] r_lo;
    logic [cbss_pkg::FIELD_W-1:0] r_hi;
    logic [ID_BITS-1:0]  r_cursor, n_cursor;
    logic                r_cvalid, n_cvalid;
    logic                r_ended, n_ended;
    logic [cbss_pkg::COUNT_W-1:0] r_count, n_count;
    logic [WAW-1:0]      r_clr, n_clr;
    logic [CCW-1:0]      r_c, n_c;
    logic [CCW-1:0]      r_start, n_start;
    logic [EFF-1:0]      r_off, n_off;
    logic [WCW-1:0]      r_wi, n_wi;
    logic                r_found, n_found;
    logic [cbss_pkg::FIELD_W-1:0] r_val, n_val;
    logic                r_end, n_end;
    logic                r_new, n_new;
    logic                r_bad, n_bad;
    logic                r_ovalid;
    logic [39:0]         r_odata;

    logic            word_we, meta_we;
    logic [WAW-1:0]  word_wa, word_ra;
    logic [W-1:0]    word_wd;
    logic [CAW-1:0]  meta_wa, meta_ra;
    logic [MW-1:0]   meta_wd;

    logic [TW-1:0]   id_ext, t_raw, t_cl, start_ext, cursor_ext, hi_ext;
    logic            is_seek, bad_id, hit_cursor, start_oob;
    logic            m_ne;
    logic [EFF-1:0]  m_min, m_max, id_off;
    logic [WCW-1:0]  first_wi, wi_inc;
    logic [W-1:0]    w_mask, w_bit;
    logic            do_commit;
    logic [ID_BITS-1:0] commit_v, base_v;
    logic [MW-1:0]   meta_rst;

    assign meta_rst   = {1'b0, {EFF{1'b1}}, {EFF{1'b0}}};
    assign id_ext     = TW'(r_id);
    assign cursor_ext = TW'(r_cursor);
    assign hi_ext     = TW'(r_hi);
    assign is_seek    = (r_kind == cbss_pkg::KIND_SEEK) || (r_kind == cbss_pkg::KIND_NEXT);
    assign bad_id     = (id_ext >> ID_BITS) != '0;
    assign id_off     = id_ext[EFF-1:0];
    assign w_bit      = {{(W-1){1'b0}}, 1'b1} << id_ext[5:0];

    assign t_raw = (r_kind == cbss_pkg::KIND_SEEK) ? TW'(r_tgt)
                 : (r_cvalid ? cursor_ext + TW'(1) : '0);
    assign t_cl       = (t_raw < TW'(r_lo)) ? TW'(r_lo) : t_raw;
    assign start_ext  = t_cl >> EFF;
    assign hit_cursor = r_cvalid && (t_cl <= cursor_ext);
    assign start_oob  = start_ext >= TW'(NCH);

    assign m_ne  = r_meta_q[MW-1];
    assign m_min = r_meta_q[2*EFF-1:EFF];
    assign m_max = r_meta_q[EFF-1:0];

    assign first_wi = WCW'(r_off >> 6);
    assign wi_inc   = r_wi + WCW'(1);
    assign w_mask   = r_word_q & ((r_wi == first_wi) ? ({W{1'b1}} << r_off[5:0]) : {W{1'b1}});
    assign base_v   = ID_BITS'(TW'(r_c[CAW-1:0]) << EFF);

    assign o_st.need_add    = (r_kind == cbss_pkg::KIND_ADD) && !bad_id;
    assign o_st.need_search = is_seek && !r_ended && !hit_cursor && !start_oob;
    assign o_st.is_clear    = (r_kind == cbss_pkg::KIND_CLEAR);
    assign o_st.clr_last    = (r_clr == WAW'(NWORD - 1));
    assign o_st.ch_hit      = m_ne && ((r_c != r_start) || (r_off <= m_min));
    assign o_st.ch_skip     = !m_ne || (r_off > m_max);
    assign o_st.ch_last     = (r_c == CCW'(NCH - 1));
    assign o_st.w_hit       = (w_mask != '0);
    assign o_st.w_last      = (r_wi == WCW'(WPC - 1));
    assign o_st.out_free    = !r_ovalid || i_m_tready;

    always_comb begin
        n_cursor  = r_cursor;
        n_cvalid  = r_cvalid;
        n_ended   = r_ended;
        n_count   = r_count;
        n_clr     = r_clr;
        n_c       = r_c;
        n_start   = r_start;
        n_off     = r_off;
        n_wi      = r_wi;
        n_found   = r_found;
        n_val     = r_val;
        n_end     = r_end;
        n_new     = r_new;
        n_bad     = r_bad;
        word_we   = 1'b0;
        meta_we   = 1'b0;
        word_wa   = '0;
        word_wd   = '0;
        meta_wa   = '0;
        meta_wd   = meta_rst;
        word_ra   = '0;
        meta_ra   = '0;
        do_commit = 1'b0;
        commit_v  = r_cursor;
        case (i_cmd)
            cbss_pkg::CMD_ACCEPT: begin
                n_found = 1'b0;
                n_val   = '0;
                n_end   = 1'b0;
                n_new   = 1'b0;
                n_bad   = 1'b0;
            end
            cbss_pkg::CMD_DISPATCH: begin
                word_ra = id_ext[ID_BITS-1:6];
                meta_ra = CAW'(id_ext >> EFF);
                case (r_kind) inside
                    cbss_pkg::KIND_ADD: n_bad = bad_id;
                    cbss_pkg::KIND_SEEK, cbss_pkg::KIND_NEXT: begin
                        if (r_ended) begin
                            n_end = 1'b1;
                        end else if (hit_cursor) begin
                            do_commit = 1'b1;
                        end else if (start_oob) begin
                            n_ended = 1'b1;
                            n_end   = 1'b1;
                        end else begin
                            n_c     = CCW'(start_ext);
                            n_start = CCW'(start_ext);
                            n_off   = t_cl[EFF-1:0];
                        end
                    end
                    cbss_pkg::KIND_REWIND: begin
                        n_cursor = '0;
                        n_cvalid = 1'b0;
                        n_ended  = 1'b0;
                    end
                    cbss_pkg::KIND_CLEAR: begin
                        n_cursor = '0;
                        n_cvalid = 1'b0;
                        n_ended  = 1'b0;
                        n_count  = '0;
                        n_clr    = '0;
                    end
                    default: ;
                endcase
            end
            cbss_pkg::CMD_CLR: begin
                word_we = 1'b1;
                word_wa = r_clr;
                meta_we = {1'b0, r_clr} < (WAW + 1)'(NCH);
                meta_wa = CAW'(r_clr);
                n_clr   = r_clr + WAW'(1);
            end
            cbss_pkg::CMD_ADD_WR: begin
                if ((r_word_q & w_bit) == '0) begin
                    word_we = 1'b1;
                    word_wa = id_ext[ID_BITS-1:6];
                    word_wd = r_word_q | w_bit;
                    meta_we = 1'b1;
                    meta_wa = CAW'(id_ext >> EFF);
                    meta_wd = {1'b1,
                               (!m_ne || id_off < m_min) ? id_off : m_min,
                               (!m_ne || id_off > m_max) ? id_off : m_max};
                    n_count = r_count + cbss_pkg::COUNT_W'(1);
                    n_new   = 1'b1;
                end
            end
            cbss_pkg::CMD_CH_RD: begin
                meta_ra = r_c[CAW-1:0];
            end
            cbss_pkg::CMD_CH_EVAL: begin
                if (o_st.ch_hit) begin
                    do_commit = 1'b1;
                    commit_v  = base_v | ID_BITS'(m_min);
                end else if (o_st.ch_skip) begin
                    if (o_st.ch_last) begin
                        n_ended = 1'b1;
                        n_end   = 1'b1;
                    end else begin
                        n_c = r_c + CCW'(1);
                    end
                end else begin
                    n_wi    = first_wi;
                    word_ra = (WAW'(r_c[CAW-1:0]) << WOB) | WAW'(first_wi);
                end
            end
            cbss_pkg::CMD_W_EVAL: begin
                if (o_st.w_hit) begin
                    do_commit = 1'b1;
                    commit_v  = base_v | (ID_BITS'(r_wi) << 6)
                              | ID_BITS'(cbss_pkg::lowest_set(w_mask));
                end else if (!o_st.w_last) begin
                    n_wi    = wi_inc;
                    word_ra = (WAW'(r_c[CAW-1:0]) << WOB) | WAW'(wi_inc);
                end else if (o_st.ch_last) begin
                    n_ended = 1'b1;
                    n_end   = 1'b1;
                end else begin
                    n_c = r_c + CCW'(1);
                end
            end
            default: ;
        endcase
        if (do_commit) begin
            n_cursor = commit_v;
            n_cvalid = 1'b1;
            if (TW'(commit_v) > hi_ext) begin
                n_ended = 1'b1;
                n_end   = 1'b1;
            end else begin
                n_found = 1'b1;
                n_val   = cbss_pkg::FIELD_W'(commit_v);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (word_we) begin
            mem_word[word_wa] <= word_wd;
        end
        r_word_q <= mem_word[word_ra];
    end

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            mem_meta[meta_wa] <= meta_wd;
        end
        r_meta_q <= mem_meta[meta_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo     <= '0;
            r_hi     <= '1;
            r_cursor <= '0;
            r_cvalid <= 1'b0;
            r_ended  <= 1'b0;
            r_count  <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == cbss_pkg::CFG_RANGE_LO) begin
                r_lo <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == cbss_pkg::CFG_RANGE_HI) begin
                r_hi <= i_cfg_data;
            end
            r_cursor <= n_cursor;
            r_cvalid <= n_cvalid;
            r_ended  <= n_ended;
            r_count  <= n_count;
            r_clr    <= n_clr;
            if (i_cmd == cbss_pkg::CMD_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == cbss_pkg::CMD_ACCEPT) begin
            r_kind <= i_kind;
            r_id   <= i_id;
            r_tgt  <= i_tgt;
        end
        r_c     <= n_c;
        r_start <= n_start;
        r_off   <= n_off;
        r_wi    <= n_wi;
        r_found <= n_found;
        r_val   <= n_val;
        r_end   <= n_end;
        r_new   <= n_new;
        r_bad   <= n_bad;
        if (i_cmd == cbss_pkg::CMD_EMIT) begin
            r_odata <= {3'b000, n_count, n_bad, n_new, n_end, n_val, n_found};
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

endmodule

FILE: rtl/core/chunked_bitmap_set_seek.sv
// Top level of the chunked bitmap set with a seeking cursor.
// An add steps through accept, dispatch, word update and result; rewind and unused kinds
// skip the update. Seek and next read and check a chunk summary per chunk visited and
// check each bitmap word scanned; summary and word memories each have a registered read.
// The next word is accepted the cycle after the result is loaded.
// After reset or a clear the bitmap's 2^(ID_BITS-6) words are swept one word a cycle.
module chunked_bitmap_set_seek #(
    parameter int ID_BITS    = 16,
    parameter int CHUNK_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // id[15:0], target[31:16]
    input  logic [2:0]  i_s_tuser,   // kind[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // found, value, at_end, newly_added, bad_id, member_count
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    cbss_pkg::t_cmd  cmd;
    cbss_pkg::t_stat st;

    cbss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    cbss_dp #(
        .ID_BITS    (ID_BITS),
        .CHUNK_BITS (CHUNK_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_kind     (i_s_tuser),
        .i_id       (i_s_tdata[15:0]),
        .i_tgt      (i_s_tdata[31:16]),
        .o_st       (st),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    a_found_xor_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[17]))
        else $error("result word reports both a member and end");

    a_bad_not_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[19] && o_m_tdata[18]))
        else $error("rejected id counted as a new member");

    a_reset_sweeps: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("input taken while the bitmap sweep is due");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second word taken before the first is dispatched");

endmodule
